### src/piecewise_poly_spline_eval_unit_assert.svh
// assertion macros for the spline evaluation unit
`ifndef PIECEWISE_POLY_SPLINE_EVAL_UNIT_ASSERT_SVH
`define PIECEWISE_POLY_SPLINE_EVAL_UNIT_ASSERT_SVH

// property holds at every clock edge out of reset
`define PPSE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property must hold in the cycle after the trigger
`define PPSE_CHECK_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

### src/ppse_pkg.sv
// shared types and constants of the spline evaluation unit
package ppse_pkg;

    localparam int TIME_W = 32;
    localparam int COEF_W = 48;
    localparam int FUNC_W = 2;
    localparam int CIDX_W = 3;
    localparam int DER_W  = 2;
    localparam int STAT_W = 2;
    localparam int USED_W = 6;
    localparam int FRAC_W = 24;
    localparam int MUL_A_W = 25;
    localparam int PROD_W = 58;
    localparam int MAX_DER = 3;

    localparam logic signed [TIME_W-1:0] ONE_Q24 = 32'sh0100_0000;
    localparam logic signed [COEF_W-1:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [COEF_W-1:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic signed [PROD_W-1:0] HALF_Q24 = 58'sd8388608;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_EVAL   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_SAT   = 2'd3
    } t_status;

    typedef struct packed {
        t_func                     func;
        logic signed [TIME_W-1:0]  seg_start;
        logic signed [TIME_W-1:0]  seg_end;
        logic [CIDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0]  coef_value;
        logic signed [TIME_W-1:0]  query_time;
        logic [DER_W-1:0]          derivative;
        logic                      wrap_time;
    } t_item;

    typedef struct packed {
        logic    load_in;
        logic    wr_seg;
        logic    zero_coef;
        logic    cnt_inc;
        logic    wr_coef;
        logic    cnt_clr;
        logic    set_res;
        t_status res_code;
        logic    rd0;
        logic    clamp;
        logic    bis_rd;
        logic    bis_upd;
        logic    sel_rd;
        logic    ofs;
        logic    h_lo;
        logic    h_hi;
        logic    h_add;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  full;
        logic  empty;
        logic  coef_bad;
        logic  bis_go;
        logic  d_over;
        logic  h_last;
        logic  zero_last;
    } t_stat;

endpackage

### src/ppse_ifs.sv
// handshake channel interfaces for items and results
interface ppse_in_if;
    import ppse_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [TIME_W-1:0] seg_start;
    logic signed [TIME_W-1:0] seg_end;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [TIME_W-1:0] query_time;
    logic [DER_W-1:0]         derivative;
    logic                     wrap_time;

    modport source (output valid, func, seg_start, seg_end, coef_index, coef_value,
                    query_time, derivative, wrap_time, input ready);
    modport sink (input valid, func, seg_start, seg_end, coef_index, coef_value,
                  query_time, derivative, wrap_time, output ready);
endinterface

interface ppse_out_if;
    import ppse_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [COEF_W-1:0] value;
    logic [STAT_W-1:0]        status;
    logic [USED_W-1:0]        segment_used;

    modport source (output valid, value, status, segment_used, input ready);
    modport sink (input valid, value, status, segment_used, output ready);
endinterface

### src/ppse_ctrl.sv
// controller state machine sequencing the spline datapath
module ppse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ppse_pkg::t_stat i_stat,
    output ppse_pkg::t_cmd  o_cmd
);
    import ppse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_ZERO, S_RD0, S_CLAMP, S_BIS, S_BCMP,
        S_OFS, S_H_LO, S_H_HI, S_H_ADD, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_code = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.func)
                    FUNC_APPEND: begin
                        o_cmd.set_res = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.res_code = ST_BAD;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.wr_seg = 1'b1;
                            n_state = S_ZERO;
                        end
                    end
                    FUNC_WRITE: begin
                        o_cmd.set_res = 1'b1;
                        if (i_stat.coef_bad) begin
                            o_cmd.res_code = ST_BAD;
                        end else begin
                            o_cmd.wr_coef = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    FUNC_CLEAR: begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state = S_DONE;
                    end
                    default: begin
                        if (i_stat.empty) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = ST_EMPTY;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD0;
                        end
                    end
                endcase
            end
            S_ZERO: begin
                o_cmd.zero_coef = 1'b1;
                if (i_stat.zero_last) begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state = S_BIS;
            end
            S_BIS: begin
                if (i_stat.bis_go) begin
                    o_cmd.bis_rd = 1'b1;
                    n_state = S_BCMP;
                end else begin
                    o_cmd.sel_rd = 1'b1;
                    n_state = S_OFS;
                end
            end
            S_BCMP: begin
                o_cmd.bis_upd = 1'b1;
                n_state = S_BIS;
            end
            S_OFS: begin
                o_cmd.ofs = 1'b1;
                n_state = i_stat.d_over ? S_DONE : S_H_LO;
            end
            S_H_LO: begin
                o_cmd.h_lo = 1'b1;
                n_state = S_H_HI;
            end
            S_H_HI: begin
                o_cmd.h_hi = 1'b1;
                n_state = S_H_ADD;
            end
            S_H_ADD: begin
                o_cmd.h_add = 1'b1;
                n_state = i_stat.h_last ? S_DONE : S_H_LO;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### src/ppse_dp.sv
// datapath: segment tables, bisection registers and horner unit
module ppse_dp #(
    parameter int MAX_SEGMENTS = 64,
    parameter int NUM_COEFS    = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppse_pkg::t_item                     i_item,
    input  ppse_pkg::t_cmd                      i_cmd,
    output ppse_pkg::t_stat                     o_stat,
    output logic signed [ppse_pkg::COEF_W-1:0]  o_value,
    output logic [ppse_pkg::STAT_W-1:0]         o_status,
    output logic [ppse_pkg::USED_W-1:0]         o_used
);
    import ppse_pkg::*;
    `include "piecewise_poly_spline_eval_unit_assert.svh"

    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CD   = MAX_SEGMENTS * NUM_COEFS;
    localparam int AW   = (CD > 1) ? $clog2(CD) : 1;
    localparam int CIW  = (NUM_COEFS > 1) ? $clog2(NUM_COEFS) : 1;
    localparam int KMAX = NUM_COEFS * NUM_COEFS * NUM_COEFS;
    localparam int KW   = $clog2(KMAX + 1);
    localparam int KCW  = COEF_W + KW + 1;
    localparam int SW   = (COEF_W + KW + 3 > 60) ? COEF_W + KW + 3 : 60;

    localparam logic [AW-1:0]         NC_A  = AW'(NUM_COEFS);
    localparam logic signed [CW:0]    ONE_H = (CW + 1)'(1);
    localparam logic signed [SW-1:0]  MAX_W = SW'(MAX48);
    localparam logic signed [SW-1:0]  MIN_W = SW'(MIN48);

    function automatic logic [KW-1:0] dfac(input int i, input int d);
        int k;
        k = 1;
        for (int j = 0; j < MAX_DER; j++) begin
            if (j < d) begin
                k = k * (i - j);
            end
        end
        return KW'(k);
    endfunction

    logic signed [TIME_W-1:0] st_mem [MAX_SEGMENTS];
    logic signed [TIME_W-1:0] en_mem [MAX_SEGMENTS];
    logic signed [COEF_W-1:0] cf_mem [CD];

    t_item                     r_item;
    logic [CW-1:0]             r_cnt;
    logic [CIW-1:0]            r_j;
    logic [CIW-1:0]            r_i;
    logic signed [TIME_W-1:0]  r_x;
    logic signed [CW:0]        r_lo;
    logic signed [CW:0]        r_hi;
    logic [IW-1:0]             r_mid;
    logic [IW-1:0]             r_sel;
    logic signed [TIME_W:0]    r_u;
    logic signed [PROD_W-1:0]  r_pl;
    logic signed [PROD_W-1:0]  r_ph;
    logic signed [KCW-1:0]     r_kc;
    logic                      r_sat;
    logic signed [COEF_W-1:0]  r_value;
    t_status                   r_status;
    logic [IW-1:0]             r_used;
    logic signed [COEF_W-1:0]  r_o_value;
    t_status                   r_o_status;
    logic [IW-1:0]             r_o_used;
    logic signed [TIME_W-1:0]  r_st_rd;
    logic signed [TIME_W-1:0]  r_en_rd;
    logic signed [COEF_W-1:0]  r_cf_rd;

    logic signed [CW+1:0]      lohi_sum;
    logic [IW-1:0]             mid_c;
    logic [IW-1:0]             sel_c;
    logic [IW-1:0]             st_addr;
    logic [IW-1:0]             en_addr;
    logic [IW-1:0]             wr_idx;
    logic [AW-1:0]             cf_waddr;
    logic [AW-1:0]             cf_raddr;
    logic signed [TIME_W-1:0]  xw;
    logic signed [TIME_W-1:0]  xc;
    logic [FRAC_W-1:0]         frac_n;
    logic signed [CW:0]        mid_s;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [SW-1:0]      sum1;
    logic signed [SW-1:0]      sat1;
    logic signed [SW-1:0]      sum2;
    logic signed [COEF_W-1:0]  sat2;
    logic                      ovf1;
    logic                      ovf2;
    logic [KW-1:0]             kfac;

    // status toward the controller
    assign o_stat.func      = r_item.func;
    assign o_stat.full      = (r_cnt == CW'(MAX_SEGMENTS));
    assign o_stat.empty     = (r_cnt == '0);
    assign o_stat.coef_bad  = (r_cnt == '0) || (int'(r_item.coef_index) >= NUM_COEFS);
    assign o_stat.bis_go    = (r_lo < r_hi);
    assign o_stat.d_over    = (int'(r_item.derivative) >= NUM_COEFS);
    assign o_stat.h_last    = (int'(r_i) == int'(r_item.derivative));
    assign o_stat.zero_last = (r_j == CIW'(NUM_COEFS - 1));

    // address generation
    assign lohi_sum = (CW + 2)'(r_lo) + (CW + 2)'(r_hi);
    assign mid_c    = lohi_sum[IW:1];
    assign sel_c    = r_hi[CW] ? '0 : r_hi[IW-1:0];
    assign wr_idx   = r_cnt[IW-1:0];
    assign mid_s    = $signed((CW + 1)'(r_mid));

    always_comb begin
        st_addr = '0;
        if (i_cmd.bis_rd) begin
            st_addr = mid_c;
        end else if (i_cmd.sel_rd) begin
            st_addr = sel_c;
        end
        en_addr = IW'(r_cnt - 1'b1);
        if (i_cmd.bis_rd) begin
            en_addr = mid_c;
        end
        if (i_cmd.wr_coef) begin
            cf_waddr = AW'(IW'(r_cnt - 1'b1)) * NC_A + AW'(r_item.coef_index);
        end else begin
            cf_waddr = AW'(wr_idx) * NC_A + AW'(r_j);
        end
        cf_raddr = AW'(r_sel) * NC_A + AW'(r_i);
    end

    // wrap and clamp of the query time
    always_comb begin
        frac_n = '0 - r_item.query_time[FRAC_W-1:0];
        xw     = r_item.query_time;
        if (r_item.wrap_time) begin
            if (r_item.query_time < 0) begin
                xw = ONE_Q24 - $signed(TIME_W'(frac_n));
            end else if (r_item.query_time > ONE_Q24) begin
                xw = $signed(TIME_W'(r_item.query_time[FRAC_W-1:0]));
            end
        end
        xc = xw;
        if (xc <= r_st_rd) begin
            xc = r_st_rd;
        end
        if (xc >= r_en_rd) begin
            xc = r_en_rd;
        end
    end

    // shared multiplier and horner accumulate
    always_comb begin
        mul_a = i_cmd.h_hi ? $signed({r_value[COEF_W-1], r_value[COEF_W-1:FRAC_W]})
                           : $signed({1'b0, r_value[FRAC_W-1:0]});
        prod  = mul_a * r_u;
        kfac  = dfac(int'(r_i), int'(r_item.derivative));
        rnd   = (r_pl + HALF_Q24) >>> FRAC_W;
        sum1  = SW'(r_ph) + SW'(rnd);
        ovf1  = 1'b0;
        sat1  = sum1;
        if (sum1 > MAX_W) begin
            sat1 = MAX_W;
            ovf1 = 1'b1;
        end else if (sum1 < MIN_W) begin
            sat1 = MIN_W;
            ovf1 = 1'b1;
        end
        sum2 = sat1 + SW'(r_kc);
        ovf2 = 1'b0;
        sat2 = sum2[COEF_W-1:0];
        if (sum2 > MAX_W) begin
            sat2 = MAX48;
            ovf2 = 1'b1;
        end else if (sum2 < MIN_W) begin
            sat2 = MIN48;
            ovf2 = 1'b1;
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_seg) begin
            st_mem[wr_idx] <= r_item.seg_start;
            en_mem[wr_idx] <= r_item.seg_end;
        end
        r_st_rd <= st_mem[st_addr];
        r_en_rd <= en_mem[en_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_coef) begin
            cf_mem[cf_waddr] <= '0;
        end else if (i_cmd.wr_coef) begin
            cf_mem[cf_waddr] <= r_item.coef_value;
        end
        r_cf_rd <= cf_mem[cf_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_item;
        end
        if (i_cmd.wr_seg) begin
            r_j <= '0;
        end else if (i_cmd.zero_coef) begin
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.set_res) begin
            r_value  <= '0;
            r_status <= i_cmd.res_code;
            r_used   <= '0;
        end
        if (i_cmd.clamp) begin
            r_x  <= xc;
            r_lo <= '0;
            r_hi <= $signed((CW + 1)'(r_cnt)) - ONE_H;
        end
        if (i_cmd.bis_rd) begin
            r_mid <= mid_c;
        end
        if (i_cmd.bis_upd) begin
            if (r_x < r_st_rd) begin
                r_hi <= mid_s - ONE_H;
            end else if (r_x > r_en_rd) begin
                r_lo <= mid_s + ONE_H;
            end else begin
                r_lo <= mid_s;
                r_hi <= mid_s;
            end
        end
        if (i_cmd.sel_rd) begin
            r_sel <= sel_c;
        end
        if (i_cmd.ofs) begin
            r_u      <= (TIME_W + 1)'(r_x) - (TIME_W + 1)'(r_st_rd);
            r_i      <= CIW'(NUM_COEFS - 1);
            r_value  <= '0;
            r_sat    <= 1'b0;
            r_status <= ST_OK;
            r_used   <= r_sel;
        end
        if (i_cmd.h_lo) begin
            r_pl <= prod;
        end
        if (i_cmd.h_hi) begin
            r_ph <= prod;
            r_kc <= $signed({1'b0, kfac}) * r_cf_rd;
        end
        if (i_cmd.h_add) begin
            r_value  <= sat2;
            r_sat    <= r_sat | ovf1 | ovf2;
            r_status <= (r_sat | ovf1 | ovf2) ? ST_SAT : ST_OK;
            r_i      <= r_i - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_value  <= r_value;
            r_o_status <= r_status;
            r_o_used   <= r_used;
        end
    end

    always_comb begin
        o_used = '0;
        for (int b = 0; b < USED_W; b++) begin
            if (b < IW) begin
                o_used[b] = r_o_used[b];
            end
        end
    end

    assign o_value  = r_o_value;
    assign o_status = r_o_status;

    `PPSE_CHECK(a_cnt_range, r_cnt <= CW'(MAX_SEGMENTS), "segment count beyond table size")
    `PPSE_CHECK(a_append_room, !i_cmd.wr_seg || (r_cnt < CW'(MAX_SEGMENTS)), "append when full")
    `PPSE_CHECK(a_sel_valid, !i_cmd.h_lo || (CW'(r_sel) < r_cnt), "segment not in table")
    `PPSE_CHECK(a_h_order, !i_cmd.h_add || (int'(r_i) >= int'(r_item.derivative)), "horner low")
    `PPSE_CHECK_NEXT(a_sel_stable, i_cmd.h_lo, $stable(r_sel), "segment changed during horner step")

endmodule

### src/piecewise_poly_spline_eval_unit.sv
// top level of the piecewise polynomial spline evaluation unit
// One transaction at a time. Append zeroes the coefficients of the new segment, one coefficient
// zeroed per cycle in the coefficient memory. Evaluate takes at most floor(log2(segments))
// bisection steps: each bisection step is one registered table read and one compare, and each
// Horner step uses one shared 25x33 multiplier twice plus a saturating add.
// A finished result sits in an output register, and the next transaction is accepted while it
// waits. The tables need no clearing pass after reset.
module piecewise_poly_spline_eval_unit #(
    parameter int MAX_SEGMENTS = 64,
    parameter int NUM_COEFS    = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ppse_in_if.sink           i_item,
    ppse_out_if.source        o_result
);
    import ppse_pkg::*;

    t_item item;
    t_cmd  cmd;
    t_stat stat;

    assign item.func       = t_func'(i_item.func);
    assign item.seg_start  = i_item.seg_start;
    assign item.seg_end    = i_item.seg_end;
    assign item.coef_index = i_item.coef_index;
    assign item.coef_value = i_item.coef_value;
    assign item.query_time = i_item.query_time;
    assign item.derivative = i_item.derivative;
    assign item.wrap_time  = i_item.wrap_time;

    ppse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ppse_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .NUM_COEFS    (NUM_COEFS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_value  (o_result.value),
        .o_status (o_result.status),
        .o_used   (o_result.segment_used)
    );

endmodule
